// File: sv/lebs_pkg.sv
package lebs_pkg;

  // Index and sequence widths of the search datapath
  localparam int unsigned BLOCK_INDEX_BITS = 32;
  localparam int unsigned SEQUENCE_BITS    = 64;

  // Widths fixed by the port fields
  localparam int unsigned BLOCK_PORT_BITS = 32;
  localparam int unsigned SEQ_PORT_BITS   = 64;
  localparam int unsigned CFG_INDEX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS   = 32;

  // Configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BLOCK_COUNT   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FIRST_BLOCK   = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_RESERVED_TAIL = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_SEARCH_KIND   = 3'd3;

  // Search phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_LAST  = 2'd2;
  localparam logic [1:0] PH_MID   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_FOUND  = 2'd0;
  localparam logic [1:0] ST_WRAP   = 2'd1;
  localparam logic [1:0] ST_NODATA = 2'd2;
  localparam logic [1:0] ST_ERROR  = 2'd3;

  // Item kinds
  localparam logic MODE_START    = 1'b0;
  localparam logic MODE_RESPONSE = 1'b1;

  // Search kinds
  localparam logic KIND_NONZERO = 1'b0;
  localparam logic KIND_HIGHEST = 1'b1;

  typedef logic [BLOCK_INDEX_BITS-1:0] index_t;
  typedef logic [SEQUENCE_BITS-1:0]    seq_t;

  typedef struct packed {
    logic [31:0] block_count;
    logic [31:0] first_block;
    logic [15:0] reserved_tail;
    logic        search_kind;
  } cfg_t;

  typedef struct packed {
    logic [1:0] phase;
    index_t     low_index;
    index_t     high_index;
    index_t     prev_mid;
    logic       prev_mid_valid;
    index_t     mid_index;
    seq_t       first_seq;
  } search_t;

  typedef struct packed {
    logic       finished;
    index_t     block;
    logic [1:0] status;
  } result_t;

  // Clamp a 32-bit block index to the largest index the datapath holds
  function automatic index_t sat_index(logic [31:0] v);
    index_t r;
    if ((64'(v) >> BLOCK_INDEX_BITS) != 64'd0) begin
      r = '1;
    end else begin
      r = index_t'(v);
    end
    return r;
  endfunction

endpackage

// File: sv/lebs_step.sv
// Next search state and result for one beat
module lebs_step (
  input  lebs_pkg::cfg_t    cfg_i,
  input  lebs_pkg::search_t state_i,
  input  logic              mode_i,
  input  logic              read_ok_i,
  input  lebs_pkg::seq_t    seq_i,
  output lebs_pkg::search_t state_o,
  output lebs_pkg::result_t result_o
);

  logic [32:0]       last_usable;
  lebs_pkg::index_t  h_low;
  lebs_pkg::index_t  h_high;
  logic              h_prev_valid;
  logic [lebs_pkg::BLOCK_INDEX_BITS:0] mid_sum;
  lebs_pkg::index_t  mid;
  logic              go_low;

  // Last usable block: negative when the sign bit is set
  assign last_usable = {1'b0, cfg_i.block_count} - {17'b0, cfg_i.reserved_tail} - 33'd1;

  // Range update in the midpoint phase, then the halving step
  always_comb begin
    go_low = (cfg_i.search_kind == lebs_pkg::KIND_HIGHEST) ? (seq_i < state_i.first_seq)
                                                          : (seq_i == '0);
    h_low        = state_i.low_index;
    h_high       = state_i.high_index;
    h_prev_valid = state_i.prev_mid_valid;
    if (state_i.phase == lebs_pkg::PH_LAST) begin
      h_prev_valid = 1'b0;
    end else if (go_low) begin
      h_high = state_i.mid_index;
    end else begin
      h_low = state_i.mid_index;
    end
    mid_sum = {1'b0, h_low} + {1'b0, h_high};
    mid     = mid_sum[lebs_pkg::BLOCK_INDEX_BITS:1];
  end

  always_comb begin
    state_o  = state_i;
    result_o = '{finished: 1'b1, block: '0, status: lebs_pkg::ST_ERROR};
    if (mode_i == lebs_pkg::MODE_START) begin
      state_o.prev_mid       = '0;
      state_o.prev_mid_valid = 1'b0;
      state_o.mid_index      = '0;
      state_o.first_seq      = '0;
      if (last_usable[32]) begin
        state_o.low_index  = '0;
        state_o.high_index = '0;
        state_o.phase      = lebs_pkg::PH_IDLE;
        result_o.status    = lebs_pkg::ST_NODATA;
      end else begin
        state_o.high_index = lebs_pkg::sat_index(last_usable[31:0]);
        state_o.low_index  = (cfg_i.search_kind == lebs_pkg::KIND_HIGHEST) ? '0
                           : lebs_pkg::sat_index(cfg_i.first_block);
        state_o.phase      = lebs_pkg::PH_FIRST;
        result_o.finished  = 1'b0;
        result_o.status    = lebs_pkg::ST_FOUND;
      end
    end else if (state_i.phase == lebs_pkg::PH_IDLE || !read_ok_i) begin
      // stray response or failed read
      state_o.phase = lebs_pkg::PH_IDLE;
    end else if (state_i.phase == lebs_pkg::PH_FIRST) begin
      if (seq_i == '0) begin
        state_o.phase   = lebs_pkg::PH_IDLE;
        result_o.status = lebs_pkg::ST_NODATA;
      end else begin
        state_o.first_seq = seq_i;
        state_o.phase     = lebs_pkg::PH_LAST;
        result_o          = '{finished: 1'b0, block: state_i.high_index,
                              status: lebs_pkg::ST_FOUND};
      end
    end else if (state_i.phase == lebs_pkg::PH_LAST && seq_i != '0) begin
      // last usable block already written: log has wrapped
      state_o.phase = lebs_pkg::PH_IDLE;
      result_o      = '{finished: 1'b1, block: state_i.high_index,
                        status: lebs_pkg::ST_WRAP};
    end else begin
      state_o.low_index      = h_low;
      state_o.high_index     = h_high;
      state_o.prev_mid_valid = h_prev_valid;
      result_o.status        = lebs_pkg::ST_FOUND;
      if (!(h_low < h_high)) begin
        // range closed
        state_o.phase  = lebs_pkg::PH_IDLE;
        result_o.block = state_i.mid_index;
      end else begin
        state_o.mid_index = mid;
        result_o.block    = mid;
        if (h_prev_valid && mid == state_i.prev_mid) begin
          state_o.phase = lebs_pkg::PH_IDLE;
        end else begin
          state_o.prev_mid       = mid;
          state_o.prev_mid_valid = 1'b1;
          state_o.phase          = lebs_pkg::PH_MID;
          result_o.finished      = 1'b0;
        end
      end
    end
  end

endmodule

// File: sv/log_end_block_search.sv
// Log end search sequencer: binary search over block sequence numbers.
// Path: an accepted input beat is held in the input register, then one pass
// of search logic writes its result beat into the result register.
// Throughput: one beat per cycle when the output is not stalled; the search
// state updates in the same pass. Reset: asynchronous, active low; clears
// config registers, the search state (idle phase) and both valid flags.
module log_end_block_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic        read_ok_i,
  input  logic [63:0] sequence_number_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        finished_o,
  output logic [31:0] block_number_o,
  output logic [1:0]  status_o
);

  lebs_pkg::cfg_t    cfg_q;
  lebs_pkg::search_t state_q, state_d;
  lebs_pkg::result_t res_d, res_q;
  logic              in_valid_q;
  logic              mode_q;
  logic              read_ok_q;
  lebs_pkg::seq_t    seq_q;
  logic              out_valid_q;
  logic              proc;
  logic              in_accept;

  // Configuration writes, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lebs_pkg::CFG_BLOCK_COUNT:   cfg_q.block_count   <= cfg_data_i;
        lebs_pkg::CFG_FIRST_BLOCK:   cfg_q.first_block   <= cfg_data_i;
        lebs_pkg::CFG_RESERVED_TAIL: cfg_q.reserved_tail <= cfg_data_i[15:0];
        lebs_pkg::CFG_SEARCH_KIND:   cfg_q.search_kind   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Beat moves from input register to result register when the latter frees up
  assign proc       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (proc) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q    <= mode_i;
      read_ok_q <= read_ok_i;
      seq_q     <= sequence_number_i[lebs_pkg::SEQUENCE_BITS-1:0];
    end
  end

  lebs_step u_step (
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .mode_i    (mode_q),
    .read_ok_i (read_ok_q),
    .seq_i     (seq_q),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  // Search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (proc) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign finished_o     = res_q.finished;
  assign block_number_o = lebs_pkg::BLOCK_PORT_BITS'(res_q.block);
  assign status_o       = res_q.status;

  // A finishing beat always returns the sequencer to idle
  a_finish_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && res_d.finished |=> state_q.phase == lebs_pkg::PH_IDLE)
    else $error("finish did not return to idle");

  // Read requests carry the found status
  a_req_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !res_q.finished |-> res_q.status == lebs_pkg::ST_FOUND)
    else $error("read request with nonzero status");

  // Midpoint phase always has a recorded midpoint
  a_mid_valid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.phase == lebs_pkg::PH_MID |-> state_q.prev_mid_valid)
    else $error("midpoint phase without recorded midpoint");

  // A held input beat is not dropped
  a_in_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !proc |=> in_valid_q)
    else $error("input beat lost");

endmodule
